>>> sv/spwf_pkg.sv
// Shared types and constants for the spectrum peak-hold and waterfall unit.
// Holds the item structs, the channel store entry and the register indexes.
// No dependencies.
package spwf_pkg;

  // Default geometry, handed to the top level as parameter defaults
  localparam int unsigned COLUMNS_DEFAULT    = 128;
  localparam int unsigned CHANNELS_DEFAULT   = 88;
  localparam int unsigned BAR_HEIGHT_DEFAULT = 32;

  // Field widths fixed by the item formats
  localparam int unsigned COL_W   = 7;
  localparam int unsigned RSSI_W  = 7;
  localparam int unsigned HGT_W   = 6;
  localparam int unsigned FLT_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned WF_W    = 32;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Waterfall store is indexed by the full column field
  localparam int unsigned WF_DEPTH = 2 ** COL_W;

  // Register reset values
  localparam logic [CFG_W-1:0] LEVEL_REFERENCE_RST     = 7'd95;
  localparam logic [CFG_W-1:0] WATERFALL_THRESHOLD_RST = 7'd88;
  localparam logic [FLT_W-1:0] FLOAT_DECAY_HALVES_RST  = 7'd1;
  localparam logic [HGT_W-1:0] PEAK_DECAY_RST          = 6'd1;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_REFERENCE     = 2'd0,
    REG_WATERFALL_THRESHOLD = 2'd1,
    REG_FLOAT_DECAY_HALVES  = 2'd2,
    REG_PEAK_DECAY          = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [RSSI_W-1:0] rssi_sample;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] out_column;
    logic [HGT_W-1:0] bar_height;
    logic             dot_valid;
    logic [ROW_W-1:0] dot_row;
    logic [WF_W-1:0]  waterfall_bits;
  } out_item_t;

  // One channel store entry: held peak and floating peak in halves
  typedef struct packed {
    logic [HGT_W-1:0] held_peak;
    logic [FLT_W-1:0] floating_peak_halves;
  } chan_entry_t;

endpackage

>>> sv/spectrum_peak_hold_waterfall_unit.sv
// Top level of the spectrum peak-hold and waterfall unit.
// Depends on spwf_pkg for item structs, store entry type and register indexes.
//
// Takes one display column and its RSSI sample per item and returns one
// result per item: the held peak bar height of the mapped channel, the row
// of the decaying floating-peak dot and the updated 32-row waterfall of the
// column. The unit sustains one item per clock cycle while out_ready does
// not stall the output; an accepted item is registered in the update stage
// and its result is loaded into the output register when that stage advances.
// The rate is set by the single read-modify-write each item makes on the
// channel store and on the waterfall store, both registered-read memories; an
// item that hits the same entry as the item just ahead of it takes the freshly
// written value through a forwarding path, so no stall is needed. Both stores
// read as zero after reset through per-entry valid flops, so there is no
// clearing pass and items are taken from the first cycle after reset. Registers
// must be written only while the unit is idle; the unit does not enforce it.
module spectrum_peak_hold_waterfall_unit #(
  parameter int unsigned COLUMNS    = spwf_pkg::COLUMNS_DEFAULT,
  parameter int unsigned CHANNELS   = spwf_pkg::CHANNELS_DEFAULT,
  parameter int unsigned BAR_HEIGHT = spwf_pkg::BAR_HEIGHT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  spwf_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output spwf_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [spwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spwf_pkg::CFG_W-1:0]       cfg_data
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned COL_W = spwf_pkg::COL_W;
  localparam int unsigned HGT_W = spwf_pkg::HGT_W;
  localparam int unsigned FLT_W = spwf_pkg::FLT_W;
  localparam int unsigned WF_W  = spwf_pkg::WF_W;
  localparam logic [HGT_W-1:0] BAR_MAX = HGT_W'(BAR_HEIGHT);
  localparam logic [FLT_W-1:0] ROW_TOP = FLT_W'(BAR_HEIGHT - 2);

  // Configuration registers
  logic [spwf_pkg::CFG_W-1:0] level_reference;
  logic [spwf_pkg::CFG_W-1:0] waterfall_threshold;
  logic [FLT_W-1:0]           float_decay_halves;
  logic [HGT_W-1:0]           peak_decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_reference     <= spwf_pkg::LEVEL_REFERENCE_RST;
      waterfall_threshold <= spwf_pkg::WATERFALL_THRESHOLD_RST;
      float_decay_halves  <= spwf_pkg::FLOAT_DECAY_HALVES_RST;
      peak_decay          <= spwf_pkg::PEAK_DECAY_RST;
    end else if (cfg_we) begin
      case (spwf_pkg::cfg_reg_t'(cfg_index))
        spwf_pkg::REG_LEVEL_REFERENCE:     level_reference     <= cfg_data;
        spwf_pkg::REG_WATERFALL_THRESHOLD: waterfall_threshold <= cfg_data;
        spwf_pkg::REG_FLOAT_DECAY_HALVES:  float_decay_halves  <= cfg_data;
        spwf_pkg::REG_PEAK_DECAY:          peak_decay          <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Column to channel table, worked out at elaboration
  logic [CH_W-1:0] chan_map [spwf_pkg::WF_DEPTH];

  for (genvar g = 0; g < spwf_pkg::WF_DEPTH; g++) begin : g_map
    localparam int unsigned RAW = (g * CHANNELS) / COLUMNS;
    localparam int unsigned CLP = (RAW >= CHANNELS) ? (CHANNELS - 1) : RAW;
    assign chan_map[g] = CH_W'(CLP);
  end

  // Front stage: channel lookup, bar height and waterfall pixel
  logic [CH_W-1:0]  s0_ch;
  logic [7:0]       s0_diff;
  logic [HGT_W-1:0] s0_height;
  logic             s0_wf_bit;

  always_comb begin
    s0_ch   = chan_map[in_data.column];
    s0_diff = {1'b0, level_reference} - {1'b0, in_data.rssi_sample};
    if (s0_diff[7]) begin
      s0_height = '0;
    end else if (s0_diff[6:0] > {1'b0, BAR_MAX}) begin
      s0_height = BAR_MAX;
    end else begin
      s0_height = s0_diff[HGT_W-1:0];
    end
    s0_wf_bit = in_data.rssi_sample < waterfall_threshold;
  end

  // Update stage registers
  logic                  s1_valid;
  logic                  s1_adv;
  logic [COL_W-1:0]      s1_col;
  logic [CH_W-1:0]       s1_ch;
  logic [HGT_W-1:0]      s1_height;
  logic                  s1_wf_bit;
  logic                  in_acc;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Stores and their valid flops
  spwf_pkg::chan_entry_t chan_mem [CHANNELS];
  logic [WF_W-1:0]       wf_mem   [spwf_pkg::WF_DEPTH];
  logic [CHANNELS-1:0]          ch_vld;
  logic [spwf_pkg::WF_DEPTH-1:0] wf_vld;

  spwf_pkg::chan_entry_t ch_rd;
  logic [WF_W-1:0]       wf_rd;
  logic                  ch_rd_vld;
  logic                  wf_rd_vld;

  // Write-back and forwarding
  logic                  wr_en;
  spwf_pkg::chan_entry_t ch_new;
  logic [WF_W-1:0]       wf_new;
  logic                  ch_byp;
  logic                  wf_byp;
  spwf_pkg::chan_entry_t ch_byp_data;
  logic [WF_W-1:0]       wf_byp_data;

  assign wr_en = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Latch the item, read both stores and note a same-entry write this edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col      <= in_data.column;
      s1_ch       <= s0_ch;
      s1_height   <= s0_height;
      s1_wf_bit   <= s0_wf_bit;
      ch_rd       <= chan_mem[s0_ch];
      wf_rd       <= wf_mem[in_data.column];
      ch_rd_vld   <= ch_vld[s0_ch];
      wf_rd_vld   <= wf_vld[in_data.column];
      ch_byp      <= wr_en && (s1_ch == s0_ch);
      wf_byp      <= wr_en && (s1_col == in_data.column);
      ch_byp_data <= ch_new;
      wf_byp_data <= wf_new;
    end
  end

  // Write back the updated entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      chan_mem[s1_ch] <= ch_new;
      wf_mem[s1_col]  <= wf_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_vld <= '0;
      wf_vld <= '0;
    end else if (wr_en) begin
      ch_vld[s1_ch]  <= 1'b1;
      wf_vld[s1_col] <= 1'b1;
    end
  end

  // Modify: peak hold with decay, floating peak, waterfall shift
  spwf_pkg::chan_entry_t ch_cur;
  logic [WF_W-1:0]       wf_cur;
  logic [FLT_W-1:0]      h2;
  logic [HGT_W-1:0]      half;
  logic                  dot_valid;
  logic [FLT_W-1:0]      row_full;

  always_comb begin
    if (ch_byp) begin
      ch_cur = ch_byp_data;
    end else if (ch_rd_vld) begin
      ch_cur = ch_rd;
    end else begin
      ch_cur = '0;
    end
    if (wf_byp) begin
      wf_cur = wf_byp_data;
    end else if (wf_rd_vld) begin
      wf_cur = wf_rd;
    end else begin
      wf_cur = '0;
    end

    if (s1_height >= ch_cur.held_peak) begin
      ch_new.held_peak = s1_height;
    end else if (ch_cur.held_peak > peak_decay) begin
      ch_new.held_peak = ch_cur.held_peak - peak_decay;
    end else begin
      ch_new.held_peak = '0;
    end

    h2 = {s1_height, 1'b0};
    if (h2 >= ch_cur.floating_peak_halves) begin
      ch_new.floating_peak_halves = h2;
    end else if (ch_cur.floating_peak_halves > float_decay_halves) begin
      ch_new.floating_peak_halves = ch_cur.floating_peak_halves - float_decay_halves;
    end else begin
      ch_new.floating_peak_halves = '0;
    end

    half      = ch_new.floating_peak_halves[FLT_W-1:1];
    dot_valid = {1'b0, half} <= ROW_TOP;
    row_full  = ROW_TOP - {1'b0, half};

    wf_new = {wf_cur[WF_W-2:0], s1_wf_bit};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_data.out_column     <= s1_col;
      out_data.bar_height     <= ch_new.held_peak;
      out_data.dot_valid      <= dot_valid;
      out_data.dot_row        <= dot_valid ? row_full[spwf_pkg::ROW_W-1:0] : '0;
      out_data.waterfall_bits <= wf_new;
    end
  end

  // Checks
  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("item taken while update stage and output are both blocked");

  a_peak_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ch_new.held_peak <= BAR_MAX)
    else $error("held peak written above bar height");

  a_float_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ch_new.floating_peak_halves <= {BAR_MAX, 1'b0})
    else $error("floating peak written above twice the bar height");

  a_dot_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.dot_valid |-> out_data.dot_row == '0)
    else $error("dot row not cleared when dot is off screen");

endmodule

>>> verif/tb_spectrum_peak_hold_waterfall_unit.sv
// Self-checking bench for spectrum_peak_hold_waterfall_unit: directed table, then random phases.
// Carries its own peak, floating-peak and waterfall predictor and compares every result item.
// Depends on spwf_pkg and the unit itself.
module tb_spectrum_peak_hold_waterfall_unit;

  localparam int unsigned COLUMNS     = spwf_pkg::COLUMNS_DEFAULT;
  localparam int unsigned CHANNELS    = spwf_pkg::CHANNELS_DEFAULT;
  localparam int unsigned BAR_HEIGHT  = spwf_pkg::BAR_HEIGHT_DEFAULT;
  localparam int unsigned COL_W       = spwf_pkg::COL_W;
  localparam int unsigned RSSI_W      = spwf_pkg::RSSI_W;
  localparam int unsigned HGT_W       = spwf_pkg::HGT_W;
  localparam int unsigned FLT_W       = spwf_pkg::FLT_W;
  localparam int unsigned ROW_W       = spwf_pkg::ROW_W;
  localparam int unsigned WF_W        = spwf_pkg::WF_W;
  localparam int unsigned CFG_W       = spwf_pkg::CFG_W;
  localparam int unsigned CFG_IDX_W   = spwf_pkg::CFG_IDX_W;
  localparam int unsigned WF_DEPTH    = spwf_pkg::WF_DEPTH;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 220;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 8;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One line of the directed table: an item, or a register write
  typedef struct packed {
    row_kind_t           kind;
    spwf_pkg::cfg_reg_t  sel;
    logic [COL_W-1:0]    col;
    logic [CFG_W-1:0]    val;
    logic                typed;
    spwf_pkg::out_item_t golden;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  spwf_pkg::in_item_t   in_data;
  logic                 out_valid;
  logic                 out_ready;
  spwf_pkg::out_item_t  out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predictor copy of the registers and stores
  logic [CFG_W-1:0] zero_level;
  logic [CFG_W-1:0] wf_threshold;
  logic [FLT_W-1:0] float_fall;
  logic [HGT_W-1:0] peak_fall;
  logic [HGT_W-1:0] held_peaks  [CHANNELS];
  logic [FLT_W-1:0] float_peaks [CHANNELS];
  logic [WF_W-1:0]  wf_history  [WF_DEPTH];

  spwf_pkg::out_item_t column_renders_due [$];
  logic                golden_armed;
  spwf_pkg::out_item_t golden_item;

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int          quiet_cycles;
  int          mismatches;
  int          items_taken;
  int          results_seen;
  int          reg_writes;

  spectrum_peak_hold_waterfall_unit #(
    .COLUMNS   (COLUMNS),
    .CHANNELS  (CHANNELS),
    .BAR_HEIGHT(BAR_HEIGHT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Render one column: update the channel peaks and the column waterfall
  function automatic spwf_pkg::out_item_t render_column(spwf_pkg::in_item_t it);
    int unsigned         chan, hgt, pk, fl;
    int                  row;
    spwf_pkg::out_item_t r;
    chan = (32'(it.column) * CHANNELS) / COLUMNS;
    if (chan >= CHANNELS) chan = CHANNELS - 1;
    hgt = (zero_level > it.rssi_sample) ? 32'(zero_level - it.rssi_sample) : 0;
    if (hgt > BAR_HEIGHT) hgt = BAR_HEIGHT;

    pk = 32'(held_peaks[chan]);
    if (hgt >= pk) pk = hgt;
    else pk = (pk > 32'(peak_fall)) ? pk - 32'(peak_fall) : 0;
    held_peaks[chan] = HGT_W'(pk);

    fl = 32'(float_peaks[chan]);
    if (2 * hgt >= fl) fl = 2 * hgt;
    else fl = (fl > 32'(float_fall)) ? fl - 32'(float_fall) : 0;
    float_peaks[chan] = FLT_W'(fl);

    row = int'(BAR_HEIGHT) - 2 - int'(float_peaks[chan] >> 1);
    r.out_column     = it.column;
    r.bar_height     = held_peaks[chan];
    r.dot_valid      = (row >= 0);
    r.dot_row        = (row >= 0) ? ROW_W'(row) : '0;
    r.waterfall_bits = {wf_history[it.column][WF_W-2:0], it.rssi_sample < wf_threshold};
    wf_history[it.column] = r.waterfall_bits;
    return r;
  endfunction

  function automatic plan_row_t item_row(logic [COL_W-1:0] col, logic [RSSI_W-1:0] rssi);
    return '{ROW_ITEM, spwf_pkg::REG_LEVEL_REFERENCE, col, rssi, 1'b0, '0};
  endfunction

  function automatic plan_row_t golden_row(logic [COL_W-1:0] col, logic [RSSI_W-1:0] rssi,
                                           spwf_pkg::out_item_t golden);
    return '{ROW_ITEM, spwf_pkg::REG_LEVEL_REFERENCE, col, rssi, 1'b1, golden};
  endfunction

  function automatic plan_row_t reg_row(spwf_pkg::cfg_reg_t sel, logic [CFG_W-1:0] val);
    return '{ROW_REG, sel, '0, val, 1'b0, '0};
  endfunction

  // Hold the sender off until every expected result has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (column_renders_due.size() != 0) @(negedge clk);
  endtask

  // Write one register while the unit is idle and mirror it in the predictor
  task automatic write_reg(spwf_pkg::cfg_reg_t sel, logic [CFG_W-1:0] val);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    case (sel)
      spwf_pkg::REG_LEVEL_REFERENCE:     zero_level   = val;
      spwf_pkg::REG_WATERFALL_THRESHOLD: wf_threshold = val;
      spwf_pkg::REG_FLOAT_DECAY_HALVES:  float_fall   = val;
      spwf_pkg::REG_PEAK_DECAY:          peak_fall    = val[HGT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one item after a random gap; return at the falling edge after acceptance
  task automatic push_column(logic [COL_W-1:0] col, logic [RSSI_W-1:0] rssi,
                             logic typed, spwf_pkg::out_item_t golden);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data      = '{column: col, rssi_sample: rssi};
    golden_armed = typed;
    golden_item  = golden;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready = ($urandom_range(99, 0) >= receiver_stall_pct);
  end

  // Check result items against the oldest expectation, then queue new ones
  always @(posedge clk) begin
    spwf_pkg::out_item_t due;
    bit                  quiet;
    if (!rst) begin
      quiet = 1'b1;
      if (out_valid && out_ready) begin
        quiet = 1'b0;
        results_seen++;
        if (column_renders_due.size() == 0) begin
          $error("result item for column %0d with nothing expected", out_data.out_column);
          mismatches++;
        end else begin
          due = column_renders_due.pop_front();
          if (out_data.out_column !== due.out_column) begin
            $error("out_column: expected %0d, got %0d", due.out_column, out_data.out_column);
            mismatches++;
          end
          if (out_data.bar_height !== due.bar_height) begin
            $error("bar_height: expected %0d, got %0d", due.bar_height, out_data.bar_height);
            mismatches++;
          end
          if (out_data.dot_valid !== due.dot_valid) begin
            $error("dot_valid: expected %0d, got %0d", due.dot_valid, out_data.dot_valid);
            mismatches++;
          end
          if (out_data.dot_row !== due.dot_row) begin
            $error("dot_row: expected %0d, got %0d", due.dot_row, out_data.dot_row);
            mismatches++;
          end
          if (out_data.waterfall_bits !== due.waterfall_bits) begin
            $error("waterfall_bits: expected %h, got %h", due.waterfall_bits,
                   out_data.waterfall_bits);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        quiet = 1'b0;
        items_taken++;
        due = render_column(in_data);
        if (golden_armed) due = golden_item;
        column_renders_due.push_back(due);
      end
      quiet_cycles = quiet ? quiet_cycles + 1 : 0;
    end
  end

  // Watchdog on cycles with no accepted item in either direction
  initial begin
    @(negedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("spectrum_peak_hold_waterfall_unit regression: fail");
    $finish;
  end

  initial begin
    plan_row_t        plan [$];
    logic [COL_W-1:0] col;
    logic [CFG_W-1:0] s_ref, s_thr, s_fd, s_pd;
    int               lvl;

    rst                = 1'b1;
    in_valid           = 1'b0;
    in_data            = '0;
    out_ready          = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = spwf_pkg::REG_LEVEL_REFERENCE;
    cfg_data           = '0;
    golden_armed       = 1'b0;
    golden_item        = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    quiet_cycles       = 0;
    mismatches         = 0;
    items_taken        = 0;
    results_seen       = 0;
    reg_writes         = 0;
    zero_level         = spwf_pkg::LEVEL_REFERENCE_RST;
    wf_threshold       = spwf_pkg::WATERFALL_THRESHOLD_RST;
    float_fall         = spwf_pkg::FLOAT_DECAY_HALVES_RST;
    peak_fall          = spwf_pkg::PEAK_DECAY_RST;
    foreach (held_peaks[i]) held_peaks[i] = '0;
    foreach (float_peaks[i]) float_peaks[i] = '0;
    foreach (wf_history[i]) wf_history[i] = '0;

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: reset values first, where the results are plain to see
    plan.push_back(golden_row(7'd0, 7'd127, '{7'd0, 6'd0, 1'b1, 5'd30, 32'd0}));
    plan.push_back(golden_row(7'd127, 7'd0, '{7'd127, 6'd32, 1'b0, 5'd0, 32'd1}));
    plan.push_back(golden_row(7'd127, 7'd127, '{7'd127, 6'd31, 1'b0, 5'd0, 32'd2}));
    plan.push_back(golden_row(7'd127, 7'd127, '{7'd127, 6'd30, 1'b0, 5'd0, 32'd4}));
    plan.push_back(golden_row(7'd127, 7'd127, '{7'd127, 6'd29, 1'b1, 5'd0, 32'd8}));
    plan.push_back(golden_row(7'd1, 7'd64, '{7'd1, 6'd31, 1'b0, 5'd0, 32'd1}));
    plan.push_back(golden_row(7'd0, 7'd95, '{7'd0, 6'd30, 1'b1, 5'd0, 32'd0}));
    // Threshold edges, full-height bar, same column and same channel back to back
    plan.push_back(item_row(7'd2, 7'd87));
    plan.push_back(item_row(7'd3, 7'd88));
    plan.push_back(item_row(7'd64, 7'd63));
    plan.push_back(item_row(7'd64, 7'd63));
    plan.push_back(item_row(7'd65, 7'd127));
    // Zero reference, widest threshold, no decay
    plan.push_back(reg_row(spwf_pkg::REG_LEVEL_REFERENCE, 7'd0));
    plan.push_back(reg_row(spwf_pkg::REG_WATERFALL_THRESHOLD, 7'd127));
    plan.push_back(reg_row(spwf_pkg::REG_FLOAT_DECAY_HALVES, 7'd0));
    plan.push_back(reg_row(spwf_pkg::REG_PEAK_DECAY, 7'd0));
    plan.push_back(item_row(7'd10, 7'd0));
    plan.push_back(item_row(7'd127, 7'd127));
    // Top reference, closed threshold, decays above their range
    plan.push_back(reg_row(spwf_pkg::REG_LEVEL_REFERENCE, 7'd127));
    plan.push_back(reg_row(spwf_pkg::REG_WATERFALL_THRESHOLD, 7'd0));
    plan.push_back(reg_row(spwf_pkg::REG_FLOAT_DECAY_HALVES, 7'd127));
    plan.push_back(reg_row(spwf_pkg::REG_PEAK_DECAY, 7'd127));
    plan.push_back(item_row(7'd20, 7'd0));
    plan.push_back(item_row(7'd20, 7'd127));
    plan.push_back(item_row(7'd21, 7'd96));
    // Decays at their stated highs
    plan.push_back(reg_row(spwf_pkg::REG_LEVEL_REFERENCE, 7'd95));
    plan.push_back(reg_row(spwf_pkg::REG_WATERFALL_THRESHOLD, 7'd88));
    plan.push_back(reg_row(spwf_pkg::REG_FLOAT_DECAY_HALVES, 7'd64));
    plan.push_back(reg_row(spwf_pkg::REG_PEAK_DECAY, 7'd32));
    plan.push_back(item_row(7'd30, 7'd63));
    plan.push_back(item_row(7'd30, 7'd127));
    plan.push_back(item_row(7'd126, 7'd64));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].sel, plan[i].val);
      else push_column(plan[i].col, plan[i].val, plan[i].typed, plan[i].golden);
    end

    // Random phases: each with its own register setting and idling pattern
    col = '0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin s_ref = 7'd95;  s_thr = 7'd88;  s_fd = 7'd1;   s_pd = 7'd1;  end
        1: begin s_ref = 7'd127; s_thr = 7'd127; s_fd = 7'd0;   s_pd = 7'd0;  end
        2: begin s_ref = 7'd127; s_thr = 7'd0;   s_fd = 7'd127; s_pd = 7'd63; end
        3: begin s_ref = 7'd40;  s_thr = 7'd64;  s_fd = 7'd64;  s_pd = 7'd32; end
        default: begin
          s_ref = CFG_W'($urandom_range(127, 0));
          s_thr = CFG_W'($urandom_range(127, 0));
          s_fd  = CFG_W'($urandom_range(1, 0) ? $urandom_range(8, 0) : $urandom_range(127, 0));
          s_pd  = CFG_W'($urandom_range(1, 0) ? $urandom_range(4, 0) : $urandom_range(63, 0));
        end
      endcase
      write_reg(spwf_pkg::REG_LEVEL_REFERENCE, s_ref);
      write_reg(spwf_pkg::REG_WATERFALL_THRESHOLD, s_thr);
      write_reg(spwf_pkg::REG_FLOAT_DECAY_HALVES, s_fd);
      write_reg(spwf_pkg::REG_PEAK_DECAY, s_pd);

      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
        default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Let the pipeline empty once mid-phase
        if (n == PHASE_ITEMS / 2) wait_drained();
        // Mostly a left-to-right sweep, with revisits and jumps
        case ($urandom_range(9, 0))
          0:       col = COL_W'($urandom_range(127, 0));
          1:       col = col;
          default: col = col + 1'b1;
        endcase
        // Keep most samples near the reference so bar heights spread over the range
        if ($urandom_range(4, 0) == 0) begin
          lvl = $urandom_range(127, 0);
        end else begin
          lvl = int'(zero_level) + 3 - int'($urandom_range(38, 0));
          if (lvl < 0) lvl = 0;
          if (lvl > 127) lvl = 127;
        end
        push_column(col, RSSI_W'(lvl), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d column items and %0d result items over %0d register writes,",
             items_taken, results_seen, reg_writes);
    $display("sweeps, revisits and jumps under four idling patterns; %0d mismatches.", mismatches);
    if (mismatches == 0 && column_renders_due.size() == 0) begin
      $display("spectrum_peak_hold_waterfall_unit regression: pass");
    end else begin
      $display("spectrum_peak_hold_waterfall_unit regression: fail");
    end
    $finish;
  end

endmodule
